>>> rtl/fjpe_pkg.sv
// Shared constants and the arctangent table for the planar joint pose extractor.
package fjpe_pkg;

   localparam int unsigned LinTolWidth = 31;
   localparam int unsigned AngTolWidth = 14;
   localparam int unsigned CsrDataWidth = 31;
   localparam int unsigned AccWidth = 32;
   localparam int unsigned MaxSteps = 32;

   // Register indexes
   localparam logic CSR_LIN_TOL = 1'b0;
   localparam logic CSR_ANG_TOL = 1'b1;

   localparam logic signed [AccWidth-1:0] HalfPiQ28 = 32'sd421657428;
   localparam logic signed [16:0] OneQ14 = 17'sd16384;

   // Arctangent of 2^-i in Q3.28
   function automatic logic signed [AccWidth-1:0] atan_lut(input logic [4:0] idx);
      logic signed [AccWidth-1:0] v;
      unique case (idx)
         5'd0:  v = 32'sd210828714;
         5'd1:  v = 32'sd124459460;
         5'd2:  v = 32'sd65760959;
         5'd3:  v = 32'sd33381290;
         5'd4:  v = 32'sd16755422;
         5'd5:  v = 32'sd8385879;
         5'd6:  v = 32'sd4193963;
         5'd7:  v = 32'sd2097109;
         5'd8:  v = 32'sd1048571;
         5'd9:  v = 32'sd524287;
         5'd10: v = 32'sd262144;
         5'd11: v = 32'sd131072;
         5'd12: v = 32'sd65536;
         5'd13: v = 32'sd32768;
         5'd14: v = 32'sd16384;
         5'd15: v = 32'sd8192;
         5'd16: v = 32'sd4096;
         5'd17: v = 32'sd2048;
         5'd18: v = 32'sd1024;
         5'd19: v = 32'sd512;
         5'd20: v = 32'sd256;
         5'd21: v = 32'sd128;
         5'd22: v = 32'sd64;
         5'd23: v = 32'sd32;
         5'd24: v = 32'sd16;
         5'd25: v = 32'sd8;
         5'd26: v = 32'sd4;
         5'd27: v = 32'sd2;
         5'd28: v = 32'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/fjpe_cordic_stage.sv
// One registered CORDIC vectoring micro-rotation.
module fjpe_cordic_stage #(
   parameter int unsigned W = 36,
   parameter int unsigned STEP = 0
) (
   input  logic                clock,
   input  logic signed [W-1:0] x_in,
   input  logic signed [W-1:0] y_in,
   input  logic signed [31:0]  z_in,
   output logic signed [W-1:0] x_out,
   output logic signed [W-1:0] y_out,
   output logic signed [31:0]  z_out
);
   import fjpe_pkg::*;

   logic signed [W-1:0] x_ff, y_ff, x_in_n, y_in_n;
   logic signed [31:0] z_ff, z_in_n, ang;

   always_comb begin
      ang = atan_lut(5'(STEP));
      if (!y_in[W-1]) begin
         x_in_n = x_in + (y_in >>> STEP);
         y_in_n = y_in - (x_in >>> STEP);
         z_in_n = z_in + ang;
      end else begin
         x_in_n = x_in - (y_in >>> STEP);
         y_in_n = y_in + (x_in >>> STEP);
         z_in_n = z_in - ang;
      end
   end

   // Advance one micro-rotation
   always_ff @(posedge clock) begin
      x_ff <= x_in_n;
      y_ff <= y_in_n;
      z_ff <= z_in_n;
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule

>>> rtl/fjpe_sqrt_stage.sv
// One registered digit step of the restoring square root.
module fjpe_sqrt_stage #(
   parameter int unsigned STEP = 0
) (
   input  logic        clock,
   input  logic [64:0] rem_in,
   input  logic [31:0] root_in,
   output logic [64:0] rem_out,
   output logic [31:0] root_out
);
   logic [64:0] rem_ff, rem_in_n, trial;
   logic [31:0] root_ff, root_in_n;

   // Try the next root bit: trial = (4*root+1) << 2*(31-STEP)
   always_comb begin
      trial = {31'd0, root_in, 2'b01} << (2 * (31 - STEP));
      if (rem_in >= trial) begin
         rem_in_n = rem_in - trial;
         root_in_n = {root_in[30:0], 1'b1};
      end else begin
         rem_in_n = rem_in;
         root_in_n = {root_in[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in_n;
      root_ff <= root_in_n;
   end

   assign rem_out = rem_ff;
   assign root_out = root_ff;
endmodule

>>> rtl/fjpe_atan2.sv
// Pipelined CORDIC atan2 with quadrant fold and Q4.12 rounding.
module fjpe_atan2 #(
   parameter int unsigned W = 36,
   parameter int unsigned STEPS = 16
) (
   input  logic               clock,
   input  logic signed [31:0] y,
   input  logic signed [31:0] x,
   output logic signed [15:0] angle
);
   import fjpe_pkg::*;

   localparam int unsigned NS = (STEPS > MaxSteps) ? MaxSteps : STEPS;

   logic signed [W-1:0] xs [NS+1];
   logic signed [W-1:0] ys [NS+1];
   logic signed [31:0] zs [NS+1];
   logic zero_p [NS+1];
   logic signed [W-1:0] x0_in, y0_in, x0_ff, y0_ff;
   logic signed [31:0] z0_in, z0_ff, zr;
   logic zero_ff;
   logic signed [15:0] angle_ff;

   // Fold the left half plane onto the right
   always_comb begin
      x0_in = W'(x);
      y0_in = W'(y);
      z0_in = '0;
      if (x < 0) begin
         if (y >= 0) begin
            x0_in = W'(y);
            y0_in = -W'(x);
            z0_in = HalfPiQ28;
         end else begin
            x0_in = -W'(y);
            y0_in = W'(x);
            z0_in = -HalfPiQ28;
         end
      end
   end

   always_ff @(posedge clock) begin
      x0_ff <= x0_in;
      y0_ff <= y0_in;
      z0_ff <= z0_in;
      zero_ff <= (x == 0) && (y == 0);
   end

   assign xs[0] = x0_ff;
   assign ys[0] = y0_ff;
   assign zs[0] = z0_ff;
   assign zero_p[0] = zero_ff;

   for (genvar i = 0; i < NS; i++) begin : g_stage
      logic zero_q;
      fjpe_cordic_stage #(.W(W), .STEP(i)) u_stage (
         .clock(clock), .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
         .x_out(xs[i+1]), .y_out(ys[i+1]), .z_out(zs[i+1])
      );
      always_ff @(posedge clock) zero_q <= zero_p[i];
      assign zero_p[i+1] = zero_q;
   end

   // Round Q3.28 to Q4.12, ties up
   assign zr = zs[NS] + 32'sd32768;
   always_ff @(posedge clock) begin
      angle_ff <= zero_p[NS] ? 16'sd0 : zr[31:16];
   end
   assign angle = angle_ff;
endmodule

>>> rtl/flat_joint_pose_extract.sv
// Top level of the planar joint pose extractor.
//
// Usage: raise req_start with the six matrix entries on the req_ ports; a
// request is taken at each clock edge where req_start is high and busy is
// low. busy is always low: the block is a pipeline and takes one request
// every cycle. rsp_valid strobes for one cycle with the results; the
// receiver cannot stall, so each result must be taken in that cycle.
// Results pass through the squaring registers, the 32 digit-per-stage
// square root stages, the CORDIC chains and the final subtraction and
// tolerance stages. Throughput is one request per cycle.
// csr_we writes lin_tolerance (index 0) or angle_tolerance (index 1); write
// only while no request is in flight. Reset clears the valid pipe and
// restores tolerances to 66 and 16; data registers are not reset.
module flat_joint_pose_extract #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_start,
   output logic                                busy,
   input  logic signed [31:0]                  req_offset_x,
   input  logic signed [31:0]                  req_offset_y,
   input  logic signed [31:0]                  req_offset_z,
   input  logic signed [15:0]                  req_rot_00,
   input  logic signed [15:0]                  req_rot_10,
   input  logic signed [15:0]                  req_rot_22,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [fjpe_pkg::CsrDataWidth-1:0]   csr_wdata,
   output logic                                rsp_valid,
   output logic signed [15:0]                  rsp_slide_angle,
   output logic [31:0]                         rsp_slide_distance,
   output logic signed [15:0]                  rsp_rotation,
   output logic                                rsp_imprecise
);
   import fjpe_pkg::*;

   localparam int unsigned NS = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
   localparam int unsigned CordLat = NS + 2;
   // sq reg(2) + 32 sqrt stages + compare reg = 35; then CORDIC + sub
   localparam int unsigned DistLat = 35;
   localparam int unsigned Lat = DistLat + CordLat + 1;

   logic [LinTolWidth-1:0] lin_tol_ff;
   logic [AngTolWidth-1:0] ang_tol_ff;
   logic [Lat-1:0] vld_ff;

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         lin_tol_ff <= LinTolWidth'(66);
         ang_tol_ff <= AngTolWidth'(16);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LIN_TOL: lin_tol_ff <= csr_wdata[LinTolWidth-1:0];
            CSR_ANG_TOL: ang_tol_ff <= csr_wdata[AngTolWidth-1:0];
            default: ;
         endcase
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[Lat-2:0], req_start};
   end
   assign busy = 1'b0;

   // Stage A: squares; flag checks for z and r22
   logic [63:0] xx_ff, yy_ff;
   logic [64:0] sq_ff;
   logic signed [31:0] xa_ff, ya_ff;
   logic [31:0] az;
   logic [16:0] dev;
   logic signed [16:0] devs;
   logic zf_ff;
   always_comb begin
      az = req_offset_z[31] ? 32'(-req_offset_z) : 32'(req_offset_z);
      devs = 17'(req_rot_22) - OneQ14;
      dev = devs[16] ? 17'(-devs) : 17'(devs);
   end
   always_ff @(posedge clock) begin
      xx_ff <= 64'($signed(req_offset_x) * $signed(req_offset_x));
      yy_ff <= 64'($signed(req_offset_y) * $signed(req_offset_y));
      xa_ff <= req_offset_x;
      ya_ff <= req_offset_y;
      zf_ff <= (az > 32'(lin_tol_ff)) || (dev > 17'(ang_tol_ff));
      sq_ff <= 65'(xx_ff) + 65'(yy_ff);
   end

   // Square root pipe, one root bit per stage
   logic [64:0] rem [33];
   logic [31:0] root [33];
   logic signed [31:0] xd [33];
   logic signed [31:0] yd [33];
   logic zfd [33];
   logic signed [31:0] xb_ff, yb_ff;
   logic zfb_ff;
   always_ff @(posedge clock) begin
      xb_ff <= xa_ff;
      yb_ff <= ya_ff;
      zfb_ff <= zf_ff;
   end
   assign rem[0] = sq_ff;
   assign root[0] = '0;
   assign xd[0] = xb_ff;
   assign yd[0] = yb_ff;
   assign zfd[0] = zfb_ff;
   for (genvar i = 0; i < 32; i++) begin : g_sqrt
      logic signed [31:0] xq, yq;
      logic zq;
      fjpe_sqrt_stage #(.STEP(i)) u_sq (
         .clock(clock), .rem_in(rem[i]), .root_in(root[i]),
         .rem_out(rem[i+1]), .root_out(root[i+1])
      );
      always_ff @(posedge clock) begin
         xq <= xd[i];
         yq <= yd[i];
         zq <= zfd[i];
      end
      assign xd[i+1] = xq;
      assign yd[i+1] = yq;
      assign zfd[i+1] = zq;
   end

   // Tiny-offset check; zero the slide inputs when tiny
   logic [31:0] dist_ff;
   logic tiny_ff, zfc_ff;
   logic signed [31:0] xc_ff, yc_ff;
   always_ff @(posedge clock) begin
      dist_ff <= root[32];
      tiny_ff <= root[32] < 32'(lin_tol_ff);
      zfc_ff <= zfd[32];
      xc_ff <= (root[32] < 32'(lin_tol_ff)) ? 32'sd0 : xd[32];
      yc_ff <= (root[32] < 32'(lin_tol_ff)) ? 32'sd0 : yd[32];
   end

   // Delay rotation entries to line up with the slide CORDIC
   logic signed [15:0] r00d [DistLat+1];
   logic signed [15:0] r10d [DistLat+1];
   assign r00d[0] = req_rot_00;
   assign r10d[0] = req_rot_10;
   for (genvar i = 0; i < DistLat; i++) begin : g_rdly
      logic signed [15:0] a_q, b_q;
      always_ff @(posedge clock) begin
         a_q <= r00d[i];
         b_q <= r10d[i];
      end
      assign r00d[i+1] = a_q;
      assign r10d[i+1] = b_q;
   end

   logic signed [15:0] slide_ang, rot_ang;
   fjpe_atan2 #(.W(36), .STEPS(CORDIC_STEPS)) u_slide (
      .clock(clock), .y(yc_ff), .x(xc_ff), .angle(slide_ang)
   );
   fjpe_atan2 #(.W(36), .STEPS(CORDIC_STEPS)) u_rot (
      .clock(clock), .y(32'(r10d[DistLat])), .x(32'(r00d[DistLat])),
      .angle(rot_ang)
   );

   // Carry side data along the CORDIC latency
   logic [31:0] distd [CordLat+1];
   logic flgd [CordLat+1];
   assign distd[0] = dist_ff;
   assign flgd[0] = tiny_ff | zfc_ff;
   for (genvar i = 0; i < CordLat; i++) begin : g_sdly
      logic [31:0] d_q;
      logic f_q;
      always_ff @(posedge clock) begin
         d_q <= distd[i];
         f_q <= flgd[i];
      end
      assign distd[i+1] = d_q;
      assign flgd[i+1] = f_q;
   end

   // Final subtraction stage
   logic signed [15:0] slide_ff, rot_ff;
   logic [31:0] dist_o_ff;
   logic flag_ff;
   always_ff @(posedge clock) begin
      slide_ff <= slide_ang;
      rot_ff <= rot_ang - slide_ang;
      dist_o_ff <= distd[CordLat];
      flag_ff <= flgd[CordLat];
   end

   assign rsp_valid = vld_ff[Lat-1];
   assign rsp_slide_angle = slide_ff;
   assign rsp_slide_distance = dist_o_ff;
   assign rsp_rotation = rot_ff;
   assign rsp_imprecise = flag_ff;
endmodule

>>> tb/flat_joint_pose_extract_tb.sv
// Testbench for the planar joint pose extractor: directed table, then random requests.
module flat_joint_pose_extract_tb;
   import fjpe_pkg::*;

   localparam int unsigned Steps = 16;
   localparam int unsigned Latency = Steps + 38;

   // One request and its prediction
   typedef struct {
      logic signed [31:0] x, y, z;
      logic signed [15:0] r00, r10, r22;
   } pose_req_t;

   typedef struct {
      logic signed [15:0] slide_angle;
      logic [31:0]        slide_distance;
      logic signed [15:0] rotation;
      logic               imprecise;
   } pose_rsp_t;

   typedef struct {
      pose_req_t  req;
      bit         has_exp;
      pose_rsp_t  exp;
   } table_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_start = 1'b0;
   logic busy;
   logic signed [31:0] req_offset_x = '0, req_offset_y = '0, req_offset_z = '0;
   logic signed [15:0] req_rot_00 = '0, req_rot_10 = '0, req_rot_22 = '0;
   logic csr_we = 1'b0;
   logic csr_index = CSR_LIN_TOL;
   logic [CsrDataWidth-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_slide_angle, rsp_rotation;
   logic [31:0] rsp_slide_distance;
   logic rsp_imprecise;

   flat_joint_pose_extract #(.CORDIC_STEPS(Steps)) u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor copy of the tolerance registers
   logic [30:0] lin_tol_q = 31'd66;
   logic [13:0] ang_tol_q = 14'd16;

   pose_rsp_t pending_poses[$];
   int errors = 0;
   int checked = 0;
   int idle_pct = 0;

   // Vectoring CORDIC angle in Q4.12
   function automatic longint cordic_angle(longint y, longint x);
      longint z, dx, dy, t;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = HalfPiQ28;
         end else begin
            x = -y; y = t; z = -HalfPiQ28;
         end
      end
      for (int i = 0; i < Steps && i < MaxSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         t = (i < 29) ? longint'(atan_lut_val(i)) : 0;
         if (y >= 0) begin
            x += dx; y -= dy; z += t;
         end else begin
            x -= dx; y += dy; z -= t;
         end
      end
      return (z + 32768) >>> 16;
   endfunction

   // Arctangent table of 2^-i, Q3.28
   function automatic longint atan_lut_val(int i);
      longint tab[29] = '{210828714, 124459460, 65760959, 33381290, 16755422, 8385879,
         4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
         4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
      return tab[i];
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic pose_rsp_t predict_pose(pose_req_t r);
      pose_rsp_t o;
      longint x, y, az, dev, slide, rot;
      longint unsigned mag;
      bit flag;
      x = r.x;
      y = r.y;
      mag = floor_sqrt(longint'(x * x) + longint'(y * y));
      flag = mag < lin_tol_q;
      slide = flag ? 0 : cordic_angle(y, x);
      rot = cordic_angle(longint'(r.r10), longint'(r.r00)) - slide;
      az = r.z < 0 ? -longint'(r.z) : longint'(r.z);
      if (az > lin_tol_q) flag = 1;
      dev = longint'(r.r22) - 16384;
      if (dev < 0) dev = -dev;
      if (dev > ang_tol_q) flag = 1;
      o.slide_angle = slide[15:0];
      o.slide_distance = mag[31:0];
      o.rotation = rot[15:0];
      o.imprecise = flag;
      return o;
   endfunction

   // Check each strobed result against the oldest prediction
   always @(posedge clock) begin
      pose_rsp_t e;
      if (!reset && rsp_valid) begin
         if (pending_poses.size() == 0) begin
            $display("%0t: unexpected result angle %0d dist %0d rot %0d flag %0b", $time,
               rsp_slide_angle, rsp_slide_distance, rsp_rotation, rsp_imprecise);
            errors++;
         end else begin
            e = pending_poses.pop_front();
            checked++;
            if (rsp_slide_angle !== e.slide_angle) begin
               $display("%0t: slide_angle expected %0d actual %0d", $time,
                  e.slide_angle, rsp_slide_angle);
               errors++;
            end
            if (rsp_slide_distance !== e.slide_distance) begin
               $display("%0t: slide_distance expected %0d actual %0d", $time,
                  e.slide_distance, rsp_slide_distance);
               errors++;
            end
            if (rsp_rotation !== e.rotation) begin
               $display("%0t: rotation expected %0d actual %0d", $time,
                  e.rotation, rsp_rotation);
               errors++;
            end
            if (rsp_imprecise !== e.imprecise) begin
               $display("%0t: imprecise expected %0b actual %0b", $time,
                  e.imprecise, rsp_imprecise);
               errors++;
            end
         end
      end
   end

   // Write one tolerance register while idle
   task automatic write_csr(logic idx, logic [CsrDataWidth-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LIN_TOL) lin_tol_q = val[30:0];
      else ang_tol_q = val[13:0];
   endtask

   // Drive one request; hold start until accepted, then drop or keep high
   task automatic send_pose(pose_req_t r, pose_rsp_t e);
      while ($urandom_range(99) < idle_pct) begin
         req_start <= 1'b0;
         @(negedge clock);
      end
      req_start <= 1'b1;
      req_offset_x <= r.x;
      req_offset_y <= r.y;
      req_offset_z <= r.z;
      req_rot_00 <= r.r00;
      req_rot_10 <= r.r10;
      req_rot_22 <= r.r22;
      do @(posedge clock); while (busy);
      pending_poses.push_back(e);
      @(negedge clock);
   endtask

   task automatic drain();
      req_start <= 1'b0;
      while (pending_poses.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_offset();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(400)) - 200;
         2: return $signed($urandom) >>> $urandom_range(31);
         default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      endcase
   endfunction

   function automatic logic signed [15:0] rand_rot(bit near_one);
      if (near_one) return 16'(32'sd16384 + $signed($urandom_range(64)) - 32);
      return 16'($urandom);
   endfunction

   function automatic pose_req_t rand_pose();
      pose_req_t r;
      r.x = rand_offset();
      r.y = rand_offset();
      r.z = ($urandom_range(1)) ? rand_offset() : $signed($urandom_range(100)) - 50;
      r.r00 = rand_rot(0);
      r.r10 = rand_rot(0);
      r.r22 = rand_rot($urandom_range(1));
      return r;
   endfunction

   table_row_t directed[$];

   function automatic table_row_t row(int x, int y, int z, int a, int b, int c,
                                      bit h = 0, int sa = 0, int sd = 0, int ro = 0,
                                      bit im = 0);
      table_row_t t;
      t.req = '{x, y, z, 16'(a), 16'(b), 16'(c)};
      t.has_exp = h;
      t.exp = '{16'(sa), 32'(sd), 16'(ro), im};
      return t;
   endfunction

   initial begin
      pose_req_t r;
      pose_rsp_t e;
      // All zero: tiny offset, angles zero, flagged by r22
      directed.push_back(row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
      // Zero offset with identity rotation
      directed.push_back(row(0, 0, 0, 16384, 0, 16384, 1, 0, 0, 0, 1));
      directed.push_back(row(65536, 0, 0, 16384, 0, 16384));
      directed.push_back(row(-65536, 0, 0, -16384, 0, 16384));
      directed.push_back(row(0, 65536, 0, 0, 16384, 16384));
      directed.push_back(row(0, -65536, 0, 0, -16384, 16400));
      directed.push_back(row(65, 0, 0, 16384, 0, 16384));
      directed.push_back(row(66, 0, 66, 16384, 0, 16401));
      directed.push_back(row(66, 0, 67, 16384, 0, 16368));
      directed.push_back(row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32767, 32767, 32767));
      directed.push_back(row(32'h80000000, 32'h80000000, 32'h80000000,
                             -32768, -32768, -32768));
      directed.push_back(row(32'h80000000, 0, 0, -32768, 0, 0));
      directed.push_back(row(32'h80000000, 32'h7FFFFFFF, 0, 32767, -32768, 16384));
      directed.push_back(row(-1, -1, -1, -1, -1, -1));
      directed.push_back(row(1, -1, 1, 1, -1, 1));
      directed.push_back(row(32'h55555555, 32'hAAAAAAAA, 32'h5555AAAA, 16'h5555, 16'hAAAA,
                             16'h2AAA));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table at reset tolerances
      foreach (directed[i]) begin
         e = predict_pose(directed[i].req);
         send_pose(directed[i].req, directed[i].has_exp ? directed[i].exp : e);
      end
      drain();

      // Random phases over several tolerance settings, extremes included
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin write_csr(CSR_LIN_TOL, 0); write_csr(CSR_ANG_TOL, 0); end
            1: begin write_csr(CSR_LIN_TOL, 31'h7FFFFFFF); write_csr(CSR_ANG_TOL, 14'h3FFF); end
            2: begin write_csr(CSR_LIN_TOL, 65536); write_csr(CSR_ANG_TOL, 16); end
            default: begin
               write_csr(CSR_LIN_TOL, $urandom_range(1) ? $urandom_range(200000) : $urandom);
               write_csr(CSR_ANG_TOL, $urandom_range(64));
            end
         endcase
         idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 80 : 9;
         for (int n = 0; n < 250; n++) begin
            r = rand_pose();
            send_pose(r, predict_pose(r));
         end
         drain();
      end
      repeat (Latency + 10) @(negedge clock);

      $display("Checked %0d results over directed extremes and seven tolerance settings.",
         checked);
      if (errors == 0 && pending_poses.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hard stop for a hung run
   initial begin
      #400000;
      $display("Timeout with %0d results outstanding.", pending_poses.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
